// ===== rtl/core/mssch_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mssch_pkg: shared types and constants for the multiset subset checker
// Table geometry, command codes, bucket row layout and helper functions.
// ----------------------------------------------------------------------------
package mssch_pkg;

    localparam int BUCKETS    = 64;   // power of two: bucket is the low value bits
    localparam int WAYS       = 4;
    localparam int KEY_BITS   = 32;
    localparam int COUNT_BITS = 16;
    localparam int VALUE_W    = 32;
    localparam int CMD_W      = 2;

    localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int WIDX_W = (WAYS > 1) ? $clog2(WAYS) : 1;

    // result queue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_LOAD   = 2'd1,
        CMD_CHECK  = 2'd2,
        CMD_FINISH = 2'd3
    } cmd_t;

    typedef logic [KEY_BITS-1:0]   key_t;
    typedef logic [COUNT_BITS-1:0] cnt_t;
    typedef logic [BKT_W-1:0]      bkt_t;
    typedef logic [WIDX_W-1:0]     widx_t;
    typedef logic [WAYS-1:0]       way_mask_t;

    typedef struct packed {
        key_t key;
        cnt_t count;
    } slot_t;

    typedef slot_t [WAYS-1:0] row_t;

    localparam int   ROW_W     = $bits(row_t);
    localparam cnt_t COUNT_MAX = '1;

    typedef struct packed {
        logic wr;
        logic set_missing;
        logic set_overflow;
    } upd_t;

    typedef struct packed {
        logic is_subset;
        logic overflow;
    } res_t;

    function automatic key_t make_key(input logic signed [VALUE_W-1:0] v);
        logic signed [63:0] ext;
        ext = 64'(v);
        return KEY_BITS'(ext);
    endfunction

    function automatic bkt_t bucket_of(input logic [VALUE_W-1:0] v);
        return BKT_W'(v & VALUE_W'(BUCKETS - 1));
    endfunction

endpackage

// ===== rtl/core/mssch_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mssch_ram: generic simple dual-port RAM
// One write port, one read port, registered read data (read-before-write).
// ----------------------------------------------------------------------------
module mssch_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/mssch_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mssch_update: bucket row update
// Compares all ways against the key and builds the new row and valid mask.
// ----------------------------------------------------------------------------
module mssch_update (
    input  mssch_pkg::cmd_t      cmd,
    input  mssch_pkg::key_t      key,
    input  mssch_pkg::row_t      row_in,
    input  mssch_pkg::way_mask_t vld_in,
    output mssch_pkg::row_t      row_out,
    output mssch_pkg::way_mask_t vld_out,
    output mssch_pkg::upd_t      upd
);
    import mssch_pkg::*;

    way_mask_t hit;
    way_mask_t free;
    logic      hit_any;
    logic      free_any;
    widx_t     hit_idx;
    widx_t     free_idx;
    cnt_t      hit_cnt;

    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            hit[w]  = vld_in[w] && (row_in[w].key == key);
            free[w] = !vld_in[w];
        end
        hit_any  = |hit;
        free_any = |free;

        // lowest matching / lowest free way wins
        hit_idx  = '0;
        free_idx = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (hit[w])
            begin
                hit_idx = WIDX_W'(w);
            end
            if (free[w])
            begin
                free_idx = WIDX_W'(w);
            end
        end
        hit_cnt = row_in[hit_idx].count;

        row_out = row_in;
        vld_out = vld_in;
        upd     = '0;

        unique case (cmd)
            CMD_LOAD:
            begin
                upd.wr = 1'b1;
                if (hit_any)
                begin
                    if (hit_cnt == COUNT_MAX)
                    begin
                        upd.set_overflow = 1'b1;   // saturate
                    end
                    else
                    begin
                        row_out[hit_idx].count = hit_cnt + cnt_t'(1);
                    end
                end
                else if (free_any)
                begin
                    vld_out[free_idx]       = 1'b1;
                    row_out[free_idx].key   = key;
                    row_out[free_idx].count = cnt_t'(1);
                end
                else
                begin
                    upd.set_overflow = 1'b1;       // bucket full, drop
                end
            end
            CMD_CHECK:
            begin
                upd.wr = 1'b1;
                if (!hit_any)
                begin
                    upd.set_missing = 1'b1;
                end
                else if (hit_cnt > cnt_t'(1))
                begin
                    row_out[hit_idx].count = hit_cnt - cnt_t'(1);
                end
                else
                begin
                    vld_out[hit_idx]       = 1'b0;
                    row_out[hit_idx].count = '0;
                end
            end
            default:
            begin
                // clear and finish leave the row alone
            end
        endcase
    end

endmodule

// ===== rtl/core/mssch_outq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mssch_outq: result queue
// Small FIFO of finish results; the head drives the output channel.
// ----------------------------------------------------------------------------
module mssch_outq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  mssch_pkg::res_t               push_data,
    input  logic                          pop,
    output mssch_pkg::res_t               head,
    output logic                          nonempty,
    output logic [mssch_pkg::QCNT_W-1:0]  occ
);
    import mssch_pkg::*;

    res_t              q_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head     = q_reg[rd_ptr_reg];
    assign nonempty = (cnt_reg != '0);
    assign occ      = cnt_reg;

endmodule

// ===== rtl/core/multiset_subset_check_hash.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multiset_subset_check_hash: counting hash table multiset subset checker
// Clear, load and check beats update a bucketed count table; finish reports.
// ----------------------------------------------------------------------------
// Takes one command beat per cycle while in_ready is high. Each beat sits
// in the input register, where the bucket row (all ways' keys and counts)
// is read from a single-read, single-write RAM, and then in the update
// stage, where the ways are compared in parallel and the row is written
// back; a row written in the same cycle it is read is forwarded, so beats
// to the same bucket may follow each other directly. A finish result
// passes both stages and then waits in a four-deep result queue;
// in_ready drops only when that queue plus finishes still in flight would be
// full. The bucket is the low bits of value, so BUCKETS is a power of two.
// Per-way valid bits sit in flip-flops that a clear empties all at once, so
// there is no clearing pass after reset.
// ----------------------------------------------------------------------------
module multiset_subset_check_hash (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [mssch_pkg::CMD_W-1:0]          cmd,
    input  logic signed [mssch_pkg::VALUE_W-1:0] value,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 is_subset,
    output logic                                 overflow
);
    import mssch_pkg::*;

    // input stage
    logic      s0_valid_reg;
    cmd_t      s0_cmd_reg;
    key_t      s0_key_reg;
    bkt_t      s0_bkt_reg;

    // update stage
    logic      s1_valid_reg;
    cmd_t      s1_cmd_reg;
    key_t      s1_key_reg;
    bkt_t      s1_bkt_reg;
    logic      s1_fwd_reg;
    logic      s1_fwd_next;
    row_t      s1_fwd_row_reg;

    way_mask_t vld_reg [BUCKETS];
    logic      missing_reg;
    logic      overflow_reg;

    logic [ROW_W-1:0] ram_rdata;
    row_t      row_cur;
    row_t      row_next;
    way_mask_t vld_cur;
    way_mask_t vld_next;
    upd_t      upd;
    logic      ram_we;

    logic      s0_fin;
    logic      s1_fin;
    logic      s1_clear;
    logic      in_fire;
    res_t      q_head;
    logic [QCNT_W-1:0] q_occ;
    logic [QCNT_W:0]   pend;

    assign in_fire  = in_valid && in_ready;
    assign s0_fin   = s0_valid_reg && (s0_cmd_reg == CMD_FINISH);
    assign s1_fin   = s1_valid_reg && (s1_cmd_reg == CMD_FINISH);
    assign s1_clear = s1_valid_reg && (s1_cmd_reg == CMD_CLEAR);

    // hold off input while queued plus in-flight finishes could fill the queue
    assign pend     = (QCNT_W + 1)'(q_occ) + (QCNT_W + 1)'(s0_fin) + (QCNT_W + 1)'(s1_fin);
    assign in_ready = (pend < (QCNT_W + 1)'(QDEPTH));

    mssch_ram #(
        .WIDTH (ROW_W),
        .DEPTH (BUCKETS)
    ) u_row_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_bkt_reg),
        .wdata (row_next),
        .raddr (s0_bkt_reg),
        .rdata (ram_rdata)
    );

    assign row_cur = s1_fwd_reg ? s1_fwd_row_reg : row_t'(ram_rdata);
    assign vld_cur = vld_reg[s1_bkt_reg];

    mssch_update u_update (
        .cmd     (s1_cmd_reg),
        .key     (s1_key_reg),
        .row_in  (row_cur),
        .vld_in  (vld_cur),
        .row_out (row_next),
        .vld_out (vld_next),
        .upd     (upd)
    );

    assign ram_we = s1_valid_reg && upd.wr;

    // RAM reads old data when the update stage writes the same bucket: forward it
    assign s1_fwd_next = s0_valid_reg && ram_we && (s1_bkt_reg == s0_bkt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s1_fwd_reg   <= 1'b0;
            missing_reg  <= 1'b0;
            overflow_reg <= 1'b0;
            for (int b = 0; b < BUCKETS; b++)
            begin
                vld_reg[b] <= '0;
            end
        end
        else
        begin
            s0_valid_reg <= in_fire;
            s1_valid_reg <= s0_valid_reg;
            s1_fwd_reg   <= s1_fwd_next;
            if (s1_clear)
            begin
                missing_reg  <= 1'b0;
                overflow_reg <= 1'b0;
                for (int b = 0; b < BUCKETS; b++)
                begin
                    vld_reg[b] <= '0;
                end
            end
            else if (ram_we)
            begin
                vld_reg[s1_bkt_reg] <= vld_next;
                if (upd.set_missing)
                begin
                    missing_reg <= 1'b1;
                end
                if (upd.set_overflow)
                begin
                    overflow_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s0_cmd_reg <= cmd_t'(cmd);
            s0_key_reg <= make_key(value);
            s0_bkt_reg <= bucket_of(value);
        end
        s1_cmd_reg     <= s0_cmd_reg;
        s1_key_reg     <= s0_key_reg;
        s1_bkt_reg     <= s0_bkt_reg;
        s1_fwd_row_reg <= row_next;
    end

    mssch_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s1_fin),
        .push_data ('{is_subset: !missing_reg, overflow: overflow_reg}),
        .pop       (out_valid && out_ready),
        .head      (q_head),
        .nonempty  (out_valid),
        .occ       (q_occ)
    );

    assign is_subset = q_head.is_subset;
    assign overflow  = q_head.overflow;

    // the credit check must keep the result queue from ever overrunning
    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fin |-> (q_occ < QCNT_W'(QDEPTH)))
        else $error("result queue overrun");

    // the pipeline never stalls once a beat is inside
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s0_valid_reg |=> s1_valid_reg)
        else $error("beat lost between stages");

    // forwarding only follows a write by the preceding beat
    a_fwd_src: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fwd_reg |-> (s1_valid_reg && $past(ram_we)))
        else $error("row forwarded without a write");

    // a clear empties both flags and all ways of bucket 0
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        s1_clear |=> (!missing_reg && !overflow_reg && (vld_reg[0] == '0)))
        else $error("clear left state behind");

endmodule
